[design/rmq_pkg.sv]
// rmq_pkg: widths, stage map, slot codes and step functions for the
// rotation matrix to quaternion pipeline
// depends on nothing; used by rmq_div and rotation_matrix_to_quaternion
package rmq_pkg;

    // operand format (signed Q2.14)
    localparam int DW     = 16;
    localparam int FB     = 14;
    localparam int ONE    = 1 << FB;

    // radicand, root and remainder widths
    localparam int RADW   = 17;
    localparam int SQW    = 16;
    localparam int SQREMW = 18;
    localparam int SQN    = SQW;

    // off-diagonal term, dividend and quotient widths
    localparam int DIFW   = DW + 1;
    localparam int NUMW   = 32;
    localparam int QB     = DW - 1;

    // stage map
    localparam int ST_SQ  = 2;
    localparam int ST_DIV = ST_SQ + SQN;
    localparam int ST_OUT = ST_DIV + QB + 1;
    localparam int NST    = ST_OUT + 1;

    // output slot of the main component
    typedef enum logic [1:0] {
        SLOT_W,
        SLOT_X,
        SLOT_Y,
        SLOT_Z
    } slot_t;

    typedef struct packed {
        logic [SQREMW-1:0] rem;
        logic [SQW-1:0]    root;
    } sq_t;

    // one digit of the restoring square root
    function automatic sq_t sqrt_step(input logic [SQREMW-1:0] rem,
                                      input logic [SQW-1:0] root,
                                      input logic [1:0] pair);
        logic [SQREMW+1:0] r;
        logic [SQREMW+1:0] t;
        sq_t o;
        r = {rem, pair};
        t = {{(SQREMW-SQW){1'b0}}, root, 2'b01};
        if (r >= t) begin
            o.rem  = SQREMW'(r - t);
            o.root = {root[SQW-2:0], 1'b1};
        end else begin
            o.rem  = SQREMW'(r);
            o.root = {root[SQW-2:0], 1'b0};
        end
        return o;
    endfunction

    // sign-extended difference and sum of two entries
    function automatic logic signed [DIFW-1:0] dsub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
        return DIFW'(a) - DIFW'(b);
    endfunction

    function automatic logic signed [DIFW-1:0] dadd(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
        return DIFW'(a) + DIFW'(b);
    endfunction

endpackage

[design/rmq_div.sv]
// rmq_div: pipelined rounding divider d * 2^FB / (2*s) for one component
// depends on rmq_pkg
module rmq_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [rmq_pkg::SQW-1:0]           root,
    input  logic signed [rmq_pkg::DIFW-1:0]   diff,
    output logic [rmq_pkg::QB-1:0]            quot,
    output logic                              ovf,
    output logic                              neg
);

    logic [rmq_pkg::NUMW-1:0] rem_reg [0:rmq_pkg::QB];
    logic [rmq_pkg::QB-1:0]   q_reg   [0:rmq_pkg::QB];
    logic [rmq_pkg::SQW:0]    den_reg [0:rmq_pkg::QB];
    logic                     ovf_reg [0:rmq_pkg::QB];
    logic                     neg_reg [0:rmq_pkg::QB];

    logic [rmq_pkg::DIFW:0]   mag_wide;
    logic [rmq_pkg::DIFW-1:0] mag;
    logic [rmq_pkg::NUMW-1:0] num;
    logic [rmq_pkg::SQW:0]    den;

    // setup: magnitude, dividend with rounding term, overflow check
    always_comb begin
        mag_wide = diff[rmq_pkg::DIFW-1] ? -{diff[rmq_pkg::DIFW-1], diff}
                                         : {1'b0, diff};
        mag      = mag_wide[rmq_pkg::DIFW-1:0];
        num      = rmq_pkg::NUMW'({mag, {rmq_pkg::FB{1'b0}}})
                 + rmq_pkg::NUMW'(root);
        den      = {root, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= (num >= rmq_pkg::NUMW'({den, {rmq_pkg::QB{1'b0}}}));
            neg_reg[0] <= diff[rmq_pkg::DIFW-1];
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < rmq_pkg::QB; k++) begin : g_step
        localparam int SH = rmq_pkg::QB - 1 - k;
        logic [rmq_pkg::NUMW-1:0] sub;
        logic                     take;
        logic [rmq_pkg::QB-1:0]   q_bit;
        assign sub   = rmq_pkg::NUMW'(den_reg[k]) << SH;
        assign take  = (rem_reg[k] >= sub);
        assign q_bit = rmq_pkg::QB'(take) << SH;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]     <= take ? rem_reg[k] - sub : rem_reg[k];
                q_reg[k+1]       <= q_reg[k] | q_bit;
                den_reg[k+1]     <= den_reg[k];
                ovf_reg[k+1]     <= ovf_reg[k];
                neg_reg[k+1]     <= neg_reg[k];
            end
        end
    end

    assign quot = q_reg[rmq_pkg::QB];
    assign ovf  = ovf_reg[rmq_pkg::QB];
    assign neg  = neg_reg[rmq_pkg::QB];

endmodule

[design/rotation_matrix_to_quaternion.sv]
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion, Q2.14
// depends on rmq_pkg and rmq_div
//
//  channel  dir  bits  beat contents
//  s_axis   in   144   m_xx m_xy m_xz m_yx m_yy m_yz m_zx m_zy m_zz
//  m_axis   out  64    quat_w quat_x quat_y quat_z
//
// one matrix per cycle sustained while m_tready stays high; an input beat passes
// through 16 square root stages and 16 divider stages (setup plus 15 quotient bits)
// aresetn clears all valid bits; payload registers are not reset
// the pipeline moves as a whole; a two-entry output (last stage plus skid) lets one
// more beat in after m_tready drops, then s_tready falls until the skid drains
module rotation_matrix_to_quaternion (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz (16 bits each, lowest first)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
    output logic [63:0]  m_tdata
);

    localparam int DW = rmq_pkg::DW;

    logic [rmq_pkg::NST-1:0] v_reg, v_next;
    logic                    adv;
    logic                    skid_valid_reg, skid_valid_next;
    logic [63:0]             skid_reg;
    logic [63:0]             out_reg;

    // stage 0: input capture
    logic signed [DW-1:0] mat_reg [0:8];

    // square root stages
    logic [rmq_pkg::RADW-1:0]         rad_reg  [0:rmq_pkg::SQN];
    logic [rmq_pkg::SQREMW-1:0]       srem_reg [0:rmq_pkg::SQN];
    logic [rmq_pkg::SQW-1:0]          root_reg [0:rmq_pkg::SQN];
    rmq_pkg::slot_t                   smain_reg[0:rmq_pkg::SQN];
    logic signed [rmq_pkg::DIFW-1:0]  d_reg    [0:rmq_pkg::SQN][0:2];

    // divider side band
    rmq_pkg::slot_t                   dmain_reg[0:rmq_pkg::QB];
    logic                             dzero_reg[0:rmq_pkg::QB];
    logic [rmq_pkg::SQW-1:0]          dhalf_reg[0:rmq_pkg::QB];

    // pipeline advance and handshake
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign m_tvalid = skid_valid_reg || v_reg[rmq_pkg::ST_OUT];
    assign m_tdata  = skid_valid_reg ? skid_reg : out_reg;

    always_comb begin
        v_next          = v_reg;
        skid_valid_next = skid_valid_reg;
        if (adv) begin
            v_next = {v_reg[rmq_pkg::NST-2:0], s_tvalid};
            if (v_reg[rmq_pkg::ST_OUT] && !m_tready) begin
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg          <= '0;
            skid_valid_reg <= 1'b0;
        end else begin
            v_reg          <= v_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v_reg[rmq_pkg::ST_OUT] && !m_tready) begin
            skid_reg <= out_reg;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                mat_reg[i] <= s_tdata[i*DW +: DW];
            end
        end
    end

    // stage 1: trace test, axis choice, radicand and off-diagonal terms
    logic signed [DW+2:0]            tr, rad_tr, rad_ax, rad_sel;
    logic signed [DW-1:0]            maa, mbb, mcc;
    rmq_pkg::slot_t                  main_sel;
    logic signed [rmq_pkg::DIFW-1:0] d0, d1, d2;

    always_comb begin
        tr     = (DW+3)'(mat_reg[0]) + (DW+3)'(mat_reg[4]) + (DW+3)'(mat_reg[8]);
        rad_tr = tr + (DW+3)'(rmq_pkg::ONE);
        main_sel = rmq_pkg::SLOT_X;
        if (mat_reg[4] > mat_reg[0]) begin
            main_sel = rmq_pkg::SLOT_Y;
        end
        if (mat_reg[8] > ((main_sel == rmq_pkg::SLOT_Y) ? mat_reg[4] : mat_reg[0])) begin
            main_sel = rmq_pkg::SLOT_Z;
        end
        unique case (main_sel)
            rmq_pkg::SLOT_Y: begin
                maa = mat_reg[4]; mbb = mat_reg[8]; mcc = mat_reg[0];
                d0  = rmq_pkg::dsub(mat_reg[2], mat_reg[6]);
                d1  = rmq_pkg::dadd(mat_reg[1], mat_reg[3]);
                d2  = rmq_pkg::dadd(mat_reg[7], mat_reg[5]);
            end
            rmq_pkg::SLOT_Z: begin
                maa = mat_reg[8]; mbb = mat_reg[0]; mcc = mat_reg[4];
                d0  = rmq_pkg::dsub(mat_reg[3], mat_reg[1]);
                d1  = rmq_pkg::dadd(mat_reg[2], mat_reg[6]);
                d2  = rmq_pkg::dadd(mat_reg[5], mat_reg[7]);
            end
            default: begin
                maa = mat_reg[0]; mbb = mat_reg[4]; mcc = mat_reg[8];
                d0  = rmq_pkg::dsub(mat_reg[7], mat_reg[5]);
                d1  = rmq_pkg::dadd(mat_reg[3], mat_reg[1]);
                d2  = rmq_pkg::dadd(mat_reg[6], mat_reg[2]);
            end
        endcase
        rad_ax = (DW+3)'(rmq_pkg::ONE) + (DW+3)'(maa)
               - ((DW+3)'(mbb) + (DW+3)'(mcc));
        if (tr > 0) begin
            main_sel = rmq_pkg::SLOT_W;
            rad_sel  = rad_tr;
            d0 = rmq_pkg::dsub(mat_reg[7], mat_reg[5]);
            d1 = rmq_pkg::dsub(mat_reg[2], mat_reg[6]);
            d2 = rmq_pkg::dsub(mat_reg[3], mat_reg[1]);
        end else begin
            rad_sel  = rad_ax[DW+2] ? '0 : rad_ax;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg[0]   <= rad_sel[rmq_pkg::RADW-1:0];
            srem_reg[0]  <= '0;
            root_reg[0]  <= '0;
            smain_reg[0] <= main_sel;
            d_reg[0][0]  <= d0;
            d_reg[0][1]  <= d1;
            d_reg[0][2]  <= d2;
        end
    end

    // square root of rad * 2^FB, one result bit per stage
    for (genvar k = 0; k < rmq_pkg::SQN; k++) begin : g_sqrt
        localparam int HI = 31 - 2*k;
        logic [31:0]  nval;
        rmq_pkg::sq_t st;
        assign nval = {1'b0, rad_reg[k], {rmq_pkg::FB{1'b0}}};
        assign st   = rmq_pkg::sqrt_step(srem_reg[k], root_reg[k], nval[HI -: 2]);
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k+1]   <= rad_reg[k];
                srem_reg[k+1]  <= st.rem;
                root_reg[k+1]  <= st.root;
                smain_reg[k+1] <= smain_reg[k];
                d_reg[k+1]     <= d_reg[k];
            end
        end
    end

    // dividers for the three minor components
    logic [rmq_pkg::QB-1:0] quot [0:2];
    logic                   ovf  [0:2];
    logic                   neg  [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_div
        rmq_div u_div (
            .aclk (aclk),
            .en   (adv),
            .root (root_reg[rmq_pkg::SQN]),
            .diff (d_reg[rmq_pkg::SQN][c]),
            .quot (quot[c]),
            .ovf  (ovf[c]),
            .neg  (neg[c])
        );
    end

    // side band alongside the dividers
    logic [rmq_pkg::SQW:0] half_sum;
    assign half_sum = {1'b0, root_reg[rmq_pkg::SQN]} + 1'b1;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dmain_reg[0] <= smain_reg[rmq_pkg::SQN];
            dzero_reg[0] <= (root_reg[rmq_pkg::SQN] == '0);
            dhalf_reg[0] <= half_sum[rmq_pkg::SQW:1];
            for (int i = 0; i < rmq_pkg::QB; i++) begin
                dmain_reg[i+1] <= dmain_reg[i];
                dzero_reg[i+1] <= dzero_reg[i];
                dhalf_reg[i+1] <= dhalf_reg[i];
            end
        end
    end

    // final stage: sign, saturation, zero root case and slot placement
    logic [DW-1:0] minor [0:2];
    logic [63:0]   out_next;

    for (genvar c = 0; c < 3; c++) begin : g_minor
        logic [DW-1:0] qext;
        assign qext     = {1'b0, quot[c]};
        assign minor[c] = ovf[c] ? (neg[c] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                                 : (neg[c] ? -qext : qext);
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (dzero_reg[rmq_pkg::QB]) begin
                out_next[j*DW +: DW] = '0;
            end else if (j == int'(dmain_reg[rmq_pkg::QB])) begin
                out_next[j*DW +: DW] = DW'(dhalf_reg[rmq_pkg::QB]);
            end else if (j > int'(dmain_reg[rmq_pkg::QB])) begin
                out_next[j*DW +: DW] = minor[j-1];
            end else begin
                out_next[j*DW +: DW] = minor[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

[design/rmq_checker.sv]
// rmq_checker: port-level assertions for rotation_matrix_to_quaternion
// depends on the top level's ports; bound below
module rmq_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    // a stalled output beat stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a nonzero quaternion carries its main component from the root
    a_main: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata != 64'd0) |->
            (($signed(m_tdata[15:0])  >= 64 && $signed(m_tdata[15:0])  <= 23171) ||
             ($signed(m_tdata[31:16]) >= 64 && $signed(m_tdata[31:16]) <= 23171) ||
             ($signed(m_tdata[47:32]) >= 64 && $signed(m_tdata[47:32]) <= 23171) ||
             ($signed(m_tdata[63:48]) >= 64 && $signed(m_tdata[63:48]) <= 23171)))
        else $error("no component in the root range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
